/* design/pfdrs_pkg.sv */
`timescale 1ns / 1ps
package pfdrs_pkg;

    localparam int FLOW_COUNT = 256;
    localparam int SLOT_COUNT = 256;
    localparam int FLOW_BITS  = $clog2(FLOW_COUNT);
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int TAG_BITS   = 16;
    localparam int TIME_BITS  = 64;
    localparam int HASH_BITS  = 32;

    localparam logic [1:0] ST_PUT_OK   = 2'd0;
    localparam logic [1:0] ST_PUT_FULL = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUT,
        S_LINK,
        S_SCAN,
        S_TEST,
        S_HEAD,
        S_SLOT,
        S_FIX,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       put_alloc;
        logic       put_link;
        logic       scan_step;
        logic       pull_head;
        logic       pull_slot;
        logic       pull_fix;
        logic       load_out;
        logic [1:0] out_code;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic flow_busy;
        logic scan_done;
        logic eligible;
        logic last;
        logic out_busy;
    } stat_t;

endpackage

/* design/pfdrs_ctrl.sv */
`timescale 1ns / 1ps
module pfdrs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_mode,
    output logic            in_ready,
    input  pfdrs_pkg::stat_t stat,
    output pfdrs_pkg::cmd_t  cmd
);
    import pfdrs_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_NONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = in_mode ? S_SCAN : S_PUT;
                end
            end
            S_PUT:
            begin
                if (stat.full)
                begin
                    code_next  = ST_PUT_FULL;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.put_alloc = 1'b1;
                    code_next     = ST_PUT_OK;
                    state_next    = stat.flow_busy ? S_LINK : S_RESULT;
                end
            end
            S_LINK:
            begin
                cmd.put_link = 1'b1;
                state_next   = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_TEST;
            end
            S_TEST:
            begin
                if (stat.eligible)
                    state_next = S_HEAD;
                else
                begin
                    code_next  = ST_NONE;
                    state_next = S_RESULT;
                end
            end
            S_HEAD:
            begin
                cmd.pull_head = 1'b1;
                state_next    = S_SLOT;
            end
            S_SLOT:
            begin
                cmd.pull_slot = 1'b1;
                code_next     = ST_RELEASED;
                state_next    = stat.last ? S_RESULT : S_FIX;
            end
            S_FIX:
            begin
                cmd.pull_fix = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                cmd.out_code = code_reg;
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* design/pfdrs_dp.sv */
`timescale 1ns / 1ps
module pfdrs_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pfdrs_pkg::cmd_t                     cmd,
    output pfdrs_pkg::stat_t                    stat,
    input  logic [pfdrs_pkg::HASH_BITS-1:0]     in_hash,
    input  logic [pfdrs_pkg::TIME_BITS-1:0]     in_time,
    input  logic [pfdrs_pkg::TAG_BITS-1:0]      in_tag,
    input  logic [pfdrs_pkg::TIME_BITS-1:0]     in_now,
    input  logic [pfdrs_pkg::TIME_BITS-1:0]     delay,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [1:0]                          out_status,
    output logic [pfdrs_pkg::TAG_BITS-1:0]      out_tag,
    output logic [7:0]                          out_flow,
    output logic [pfdrs_pkg::TIME_BITS-1:0]     out_time
);
    import pfdrs_pkg::*;

    logic [TIME_BITS-1:0] ht_mem   [FLOW_COUNT];
    logic [SLOT_BITS-1:0] head_mem [FLOW_COUNT];
    logic [SLOT_BITS-1:0] tail_mem [FLOW_COUNT];
    logic [TAG_BITS-1:0]  tag_mem  [SLOT_COUNT];
    logic [TIME_BITS-1:0] time_mem [SLOT_COUNT];
    logic [SLOT_BITS-1:0] nxt_mem  [SLOT_COUNT];
    logic [SLOT_BITS-1:0] stk_mem  [SLOT_COUNT];

    logic [FLOW_BITS-1:0] flow_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic [FLOW_COUNT-1:0] nonempty_reg;
    logic [SLOT_BITS:0]    fill_reg;
    logic [SLOT_BITS:0]    sp_reg;
    logic [FLOW_BITS:0]    cnt_reg;
    logic                  rd_v_reg;
    logic [FLOW_BITS-1:0]  rd_idx_reg;
    logic                  found_reg;
    logic [FLOW_BITS-1:0]  best_reg;
    logic [TIME_BITS-1:0]  best_time_reg;
    logic [SLOT_BITS-1:0]  alloc_reg;
    logic                  last_reg;
    logic [TAG_BITS-1:0]   rel_tag_reg;
    logic [TIME_BITS-1:0]  rel_time_reg;

    logic [TIME_BITS-1:0] ht_q, time_q;
    logic [SLOT_BITS-1:0] head_q, tail_q, nxt_q, stk_q;
    logic [TAG_BITS-1:0]  tag_q;

    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [TAG_BITS-1:0]  out_tag_reg;
    logic [7:0]           out_flow_reg;
    logic [TIME_BITS-1:0] out_time_reg;

    logic [SLOT_BITS-1:0] alloc_idx;
    logic [SLOT_BITS:0]   sp_dec;
    logic [FLOW_BITS-1:0] tail_addr;
    logic [SLOT_BITS-1:0] time_addr;
    logic [TIME_BITS:0]   due;
    logic                 take;

    assign sp_dec    = sp_reg - 1'b1;
    assign alloc_idx = (fill_reg < (SLOT_BITS+1)'(SLOT_COUNT)) ? fill_reg[SLOT_BITS-1:0] : stk_q;
    assign tail_addr = cmd.put_alloc ? flow_reg : best_reg;
    assign time_addr = cmd.pull_slot ? nxt_q : head_q;
    assign due       = {1'b0, best_time_reg} + {1'b0, delay};
    assign take      = rd_v_reg && nonempty_reg[rd_idx_reg] &&
                       (!found_reg || ht_q < best_time_reg);

    assign stat.full      = (fill_reg == (SLOT_BITS+1)'(SLOT_COUNT)) && (sp_reg == '0);
    assign stat.flow_busy = nonempty_reg[flow_reg];
    assign stat.scan_done = (cnt_reg == (FLOW_BITS+1)'(FLOW_COUNT)) && !rd_v_reg;
    assign stat.eligible  = found_reg && !due[TIME_BITS] && (due[TIME_BITS-1:0] <= now_reg);
    assign stat.last      = last_reg;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // flow memories
    always_ff @(posedge clk)
    begin
        ht_q   <= ht_mem[cnt_reg[FLOW_BITS-1:0]];
        head_q <= head_mem[best_reg];
        tail_q <= tail_mem[tail_addr];
        if (cmd.put_alloc)
            tail_mem[flow_reg] <= alloc_idx;
        if (cmd.put_alloc && !nonempty_reg[flow_reg])
        begin
            head_mem[flow_reg] <= alloc_idx;
            ht_mem[flow_reg]   <= time_reg;
        end
        if (cmd.pull_slot && !last_reg)
            head_mem[best_reg] <= nxt_q;
        if (cmd.pull_fix)
            ht_mem[best_reg] <= time_q;
    end

    // slot memories and free stack
    always_ff @(posedge clk)
    begin
        tag_q  <= tag_mem[head_q];
        time_q <= time_mem[time_addr];
        nxt_q  <= nxt_mem[head_q];
        stk_q  <= stk_mem[sp_dec[SLOT_BITS-1:0]];
        if (cmd.put_alloc)
        begin
            tag_mem[alloc_idx]  <= tag_reg;
            time_mem[alloc_idx] <= time_reg;
        end
        if (cmd.put_link)
            nxt_mem[tail_q] <= alloc_reg;
        if (cmd.pull_head)
            stk_mem[sp_reg[SLOT_BITS-1:0]] <= head_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg  <= '0;
            fill_reg      <= '0;
            sp_reg        <= '0;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                cnt_reg   <= '0;
                rd_v_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_v_reg <= (cnt_reg < (FLOW_BITS+1)'(FLOW_COUNT));
                if (cnt_reg < (FLOW_BITS+1)'(FLOW_COUNT))
                    cnt_reg <= cnt_reg + 1'b1;
                if (take)
                    found_reg <= 1'b1;
            end
            if (cmd.put_alloc)
            begin
                nonempty_reg[flow_reg] <= 1'b1;
                if (fill_reg < (SLOT_BITS+1)'(SLOT_COUNT))
                    fill_reg <= fill_reg + 1'b1;
                else
                    sp_reg <= sp_dec;
            end
            if (cmd.pull_head)
                sp_reg <= sp_reg + 1'b1;
            if (cmd.pull_slot && last_reg)
                nonempty_reg[best_reg] <= 1'b0;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            flow_reg <= in_hash[FLOW_BITS-1:0];
            time_reg <= in_time;
            tag_reg  <= in_tag;
            now_reg  <= in_now;
        end
        if (cmd.scan_step)
            rd_idx_reg <= cnt_reg[FLOW_BITS-1:0];
        if (cmd.scan_step && take)
        begin
            best_reg      <= rd_idx_reg;
            best_time_reg <= ht_q;
        end
        if (cmd.put_alloc)
            alloc_reg <= alloc_idx;
        if (cmd.pull_head)
            last_reg <= (head_q == tail_q);
        if (cmd.pull_slot)
        begin
            rel_tag_reg  <= tag_q;
            rel_time_reg <= time_q;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_code;
            if (cmd.out_code == ST_RELEASED)
            begin
                out_tag_reg  <= rel_tag_reg;
                out_flow_reg <= 8'(best_reg);
                out_time_reg <= rel_time_reg;
            end
            else
            begin
                out_tag_reg  <= '0;
                out_flow_reg <= '0;
                out_time_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_tag    = out_tag_reg;
    assign out_flow   = out_flow_reg;
    assign out_time   = out_time_reg;

endmodule

/* design/per_flow_delay_release_scheduler_top.sv */
`timescale 1ns / 1ps
// per-flow delay release scheduler: a put (s_tuser = 0) appends a packet tag and
// its arrival time to flow hash[7:0], taking a slot from a shared store of 256,
// or reports full when no slot is left; a pull (s_tuser = 1) finds the non-empty
// flow with the earliest head time (lower flow wins a tie) and releases that head
// when head time plus release_delay, taken without wrap, is at most current_time.
// one result per request. a put allocates the slot, then links the old tail when
// the flow already holds packets; a pull scans the head-time memory at one flow
// per cycle, tests the best flow, and on a release frees the head slot, reads it
// out and, unless it was the last, fixes the flow's head time. a result still
// stalled in the output register holds the next result back until it drains.
// one request is in flight at a time; a finished result waits in the output
// register while the next request is taken. release_delay is written over the
// cfg channel and resets to zero; no clearing pass is needed after reset.
module per_flow_delay_release_scheduler_top
(
    input  logic         clk,
    input  logic         rst_n,
    // request
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [175:0] s_tdata,   // flow_hash[31:0], arrival_time[95:32],
                                    // packet_tag[111:96], current_time[175:112]
    input  logic [0:0]   s_tuser,   // mode (0 put, 1 pull)
    // result
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // released_tag[15:0], released_flow[23:16],
                                    // released_time[87:24]
    output logic [1:0]   m_tuser,   // status
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data
);
    import pfdrs_pkg::*;

    logic [TIME_BITS-1:0] delay_reg;
    cmd_t                 cmd;
    stat_t                stat;
    logic [1:0]           status;
    logic [TAG_BITS-1:0]  rel_tag;
    logic [7:0]           rel_flow;
    logic [TIME_BITS-1:0] rel_time;

    // release delay register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= '0;
        else if (cfg_valid && cfg_ready)
            delay_reg <= cfg_data;
    end

    pfdrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfdrs_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_hash    (s_tdata[31:0]),
        .in_time    (s_tdata[95:32]),
        .in_tag     (s_tdata[111:96]),
        .in_now     (s_tdata[175:112]),
        .delay      (delay_reg),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (status),
        .out_tag    (rel_tag),
        .out_flow   (rel_flow),
        .out_time   (rel_time)
    );

    assign m_tuser = status;
    assign m_tdata = {rel_time, rel_flow, rel_tag};

    // only a release carries a payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_RELEASED) |-> (m_tdata == '0))
        else $error("non-release result with nonzero payload");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

endmodule
